// ===== rtl/core/elevator_scan_scheduler_assert.svh =====
// Assertion macros for the elevator scan scheduler.
// Expects clk and arst_n in the including scope; no other dependencies.
`ifndef ELEVATOR_SCAN_SCHEDULER_ASSERT_SVH
`define ELEVATOR_SCAN_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define ESS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ESS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ess_pkg.sv =====
// Shared types and constants for the elevator scan scheduler.
// No dependencies.
`timescale 1ns / 1ps

package ess_pkg;

	localparam int FLOORS    = 10;
	localparam int TIME_BITS = 16;
	localparam int FLOOR_W   = 4;
	localparam int LOAD_W    = 4;
	localparam int IDX_W     = $clog2(FLOORS);

	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(FLOORS - 1);
	localparam logic [FLOOR_W-1:0] TOP_FLOOR  = FLOOR_W'(FLOORS);
	localparam logic [LOAD_W-1:0]  CAP_RESET  = LOAD_W'(4);

	typedef enum logic [0:0] {
		OP_REGISTER = 1'b0,
		OP_TICK     = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ABSENT  = 2'd0,
		ST_WAITING = 2'd1,
		ST_RIDING  = 2'd2
	} slot_status_t;

	typedef struct packed {
		slot_status_t         status;
		logic [FLOOR_W-1:0]   dest;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		slot_t            data;
	} slot_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REG,
		S_ALIGHT,
		S_BOARD,
		S_AHEAD
	} seq_state_t;

endpackage

// ===== rtl/core/ess_slot_store.sv =====
// Per-floor passenger slots: status and destination, one read and one write port.
// Depends on ess_pkg.
`timescale 1ns / 1ps

module ess_slot_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ess_pkg::slot_wr_t             wr,
	input  logic [ess_pkg::IDX_W-1:0]     rd_addr,
	output ess_pkg::slot_t                rd_data
);

	ess_pkg::slot_status_t             status_q [ess_pkg::FLOORS];
	logic [ess_pkg::FLOOR_W-1:0]       dest_q   [ess_pkg::FLOORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ess_pkg::FLOORS; i++) begin
				status_q[i] <= ess_pkg::ST_ABSENT;
			end
		end else if (wr.en && wr.addr <= ess_pkg::LAST_IDX) begin
			status_q[wr.addr] <= wr.data.status;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.addr <= ess_pkg::LAST_IDX) begin
			dest_q[wr.addr] <= wr.data.dest;
		end
	end

	always_comb begin
		if (rd_addr <= ess_pkg::LAST_IDX) begin
			rd_data.status = status_q[rd_addr];
			rd_data.dest   = dest_q[rd_addr];
		end else begin
			rd_data.status = ess_pkg::ST_ABSENT;
			rd_data.dest   = '0;
		end
	end

endmodule

// ===== rtl/core/elevator_scan_scheduler.sv =====
// Elevator scan scheduler: a register item takes an accept step and a slot update; a tick item
// makes two passes of the sequencer over the slot store, one slot per cycle: an alight pass, a
// boarding step, then a look-ahead pass. A tick with all slots empty ends after the alight pass.
// busy is high from the cycle after acceptance until the item is finished. A result, given only
// for a tick in which a rider alights or boards, is shown for one cycle with done high and
// cannot be stalled; it appears in the first cycle with busy low, and a new item may be
// accepted in that same cycle. Depends on ess_pkg, ess_slot_store.
`timescale 1ns / 1ps
`include "elevator_scan_scheduler_assert.svh"

module elevator_scan_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [ess_pkg::FLOOR_W-1:0]     origin_floor,
	input  logic [ess_pkg::FLOOR_W-1:0]     dest_floor,
	input  logic                            cfg_we,
	input  logic [ess_pkg::LOAD_W-1:0]      cfg_data,
	output logic                            done,
	output logic [ess_pkg::FLOOR_W-1:0]     car_floor,
	output logic [ess_pkg::TIME_BITS-1:0]   elapsed,
	output logic [ess_pkg::LOAD_W-1:0]      car_load,
	output logic                            all_served
);

	ess_pkg::seq_state_t               state_q, state_d;
	logic [ess_pkg::IDX_W-1:0]         idx_q, idx_d;
	logic [ess_pkg::FLOOR_W-1:0]       org_q, org_d;
	logic [ess_pkg::FLOOR_W-1:0]       dst_q, dst_d;
	logic [ess_pkg::FLOOR_W-1:0]       nf_q, nf_d;
	logic [ess_pkg::FLOOR_W-1:0]       floor_q, floor_d;
	logic                              down_q, down_d;
	logic [ess_pkg::TIME_BITS-1:0]     count_q, count_d;
	logic [ess_pkg::LOAD_W-1:0]        riders_q, riders_d;
	logic [ess_pkg::LOAD_W-1:0]        cap_q;
	logic                              any_q, any_d;
	logic                              event_q, event_d;
	logic                              ahead_q, ahead_d;
	logic                              act_q, act_d;
	logic                              done_q, done_d;
	logic [ess_pkg::FLOOR_W-1:0]       car_floor_q;
	logic [ess_pkg::TIME_BITS-1:0]     elapsed_q;
	logic [ess_pkg::LOAD_W-1:0]        car_load_q;
	logic                              all_served_q;

	ess_pkg::slot_wr_t                 wr;
	ess_pkg::slot_t                    rd;

	logic [ess_pkg::FLOOR_W-1:0]       slot_floor;
	logic                              slot_active;
	logic                              slot_ahead;
	logic                              any_now;
	logic                              ahead_now;
	logic                              act_now;

	ess_slot_store u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (idx_q),
		.rd_data (rd)
	);

	// shared compare unit for the slot under the scan index
	always_comb begin
		slot_floor  = ess_pkg::FLOOR_W'(idx_q) + ess_pkg::FLOOR_W'(1);
		slot_active = (rd.status != ess_pkg::ST_ABSENT);
		if (down_q) begin
			slot_ahead = slot_active && (slot_floor < floor_q || rd.dest < floor_q);
		end else begin
			slot_ahead = slot_active && (slot_floor > floor_q || rd.dest > floor_q);
		end
		any_now   = any_q | slot_active;
		ahead_now = ahead_q | slot_ahead;
		act_now   = act_q | slot_active;
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		org_d    = org_q;
		dst_d    = dst_q;
		nf_d     = nf_q;
		floor_d  = floor_q;
		down_d   = down_q;
		count_d  = count_q;
		riders_d = riders_q;
		any_d    = any_q;
		event_d  = event_q;
		ahead_d  = ahead_q;
		act_d    = act_q;
		done_d   = 1'b0;
		wr.en    = 1'b0;
		wr.addr  = idx_q;
		wr.data  = rd;

		unique case (state_q)
			ess_pkg::S_IDLE: begin
				if (start) begin
					org_d   = origin_floor;
					dst_d   = dest_floor;
					any_d   = 1'b0;
					event_d = 1'b0;
					if (ess_pkg::op_t'(opcode) == ess_pkg::OP_REGISTER) begin
						idx_d   = ess_pkg::IDX_W'(origin_floor - ess_pkg::FLOOR_W'(1));
						state_d = ess_pkg::S_REG;
					end else begin
						idx_d = '0;
						if (down_q) begin
							nf_d = (floor_q != '0) ? floor_q - ess_pkg::FLOOR_W'(1) : '0;
						end else begin
							nf_d = floor_q + ess_pkg::FLOOR_W'(1);
						end
						state_d = ess_pkg::S_ALIGHT;
					end
				end
			end
			ess_pkg::S_REG: begin
				if (org_q != '0 && org_q <= ess_pkg::TOP_FLOOR &&
				    dst_q != '0 && dst_q <= ess_pkg::TOP_FLOOR &&
				    rd.status != ess_pkg::ST_RIDING) begin
					wr.en          = 1'b1;
					wr.data.status = ess_pkg::ST_WAITING;
					wr.data.dest   = dst_q;
				end
				state_d = ess_pkg::S_IDLE;
			end
			ess_pkg::S_ALIGHT: begin
				any_d = any_now;
				if (rd.status == ess_pkg::ST_RIDING && rd.dest == nf_q) begin
					wr.en          = 1'b1;
					wr.data.status = ess_pkg::ST_ABSENT;
					event_d        = 1'b1;
					if (riders_q != '0) begin
						riders_d = riders_q - ess_pkg::LOAD_W'(1);
					end
				end
				if (idx_q == ess_pkg::LAST_IDX) begin
					if (any_now) begin
						floor_d = nf_q;
						count_d = count_q + ess_pkg::TIME_BITS'(1);
						idx_d   = ess_pkg::IDX_W'(nf_q - ess_pkg::FLOOR_W'(1));
						state_d = ess_pkg::S_BOARD;
					end else begin
						state_d = ess_pkg::S_IDLE;
					end
				end else begin
					idx_d = idx_q + ess_pkg::IDX_W'(1);
				end
			end
			ess_pkg::S_BOARD: begin
				if (floor_q != '0 && floor_q <= ess_pkg::TOP_FLOOR &&
				    rd.status == ess_pkg::ST_WAITING && riders_q < cap_q) begin
					wr.en          = 1'b1;
					wr.data.status = ess_pkg::ST_RIDING;
					event_d        = 1'b1;
					riders_d       = riders_q + ess_pkg::LOAD_W'(1);
				end
				idx_d   = '0;
				ahead_d = 1'b0;
				act_d   = 1'b0;
				state_d = ess_pkg::S_AHEAD;
			end
			ess_pkg::S_AHEAD: begin
				ahead_d = ahead_now;
				act_d   = act_now;
				if (idx_q == ess_pkg::LAST_IDX) begin
					priority if (floor_q >= ess_pkg::TOP_FLOOR) begin
						down_d = 1'b1;
					end else if (floor_q <= ess_pkg::FLOOR_W'(1)) begin
						down_d = 1'b0;
					end else if (!ahead_now) begin
						down_d = ~down_q;
					end
					done_d  = event_q;
					state_d = ess_pkg::S_IDLE;
				end else begin
					idx_d = idx_q + ess_pkg::IDX_W'(1);
				end
			end
			default: begin
				state_d = ess_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ess_pkg::S_IDLE;
			idx_q    <= '0;
			floor_q  <= '0;
			down_q   <= 1'b0;
			count_q  <= '1;
			riders_q <= '0;
			cap_q    <= ess_pkg::CAP_RESET;
			any_q    <= 1'b0;
			event_q  <= 1'b0;
			ahead_q  <= 1'b0;
			act_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			floor_q  <= floor_d;
			down_q   <= down_d;
			count_q  <= count_d;
			riders_q <= riders_d;
			any_q    <= any_d;
			event_q  <= event_d;
			ahead_q  <= ahead_d;
			act_q    <= act_d;
			done_q   <= done_d;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		org_q <= org_d;
		dst_q <= dst_d;
		nf_q  <= nf_d;
		if (done_d) begin
			car_floor_q  <= floor_q;
			elapsed_q    <= count_q;
			car_load_q   <= riders_q;
			all_served_q <= ~act_now;
		end
	end

	assign busy       = (state_q != ess_pkg::S_IDLE);
	assign done       = done_q;
	assign car_floor  = car_floor_q;
	assign elapsed    = elapsed_q;
	assign car_load   = car_load_q;
	assign all_served = all_served_q;

	`ESS_ASSERT_NOW(a_done_when_idle, done, !busy, "result shown while busy")
	`ESS_ASSERT_NEXT(a_tick_goes_busy, start && !busy && opcode == ess_pkg::OP_TICK, busy, "no tick")
	`ESS_ASSERT_NOW(a_floor_in_range, done, car_floor != '0 && car_floor <= ess_pkg::TOP_FLOOR, "floor")
	`ESS_ASSERT_NOW(a_served_empty, done && all_served, car_load == '0, "all served with riders aboard")

endmodule

// ===== tb/sv/elevator_scan_scheduler_tb.sv =====
// Self-checking bench for elevator_scan_scheduler: directed and random passenger and tick items,
// checked against a scan-scheme car model kept in the bench.
// Depends on ess_pkg and elevator_scan_scheduler.
`timescale 1ns / 1ps

module elevator_scan_scheduler_tb;

	localparam int LIMIT = 400000;

	typedef struct {
		ess_pkg::op_t                      op;
		logic [ess_pkg::FLOOR_W-1:0]       org;
		logic [ess_pkg::FLOOR_W-1:0]       dst;
	} request_t;

	typedef struct packed {
		logic [ess_pkg::FLOOR_W-1:0]       at_floor;
		logic [ess_pkg::TIME_BITS-1:0]     moves;
		logic [ess_pkg::LOAD_W-1:0]        load;
		logic                              served;
	} stop_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic                              opcode = 1'b0;
	logic [ess_pkg::FLOOR_W-1:0]       origin_floor = '0;
	logic [ess_pkg::FLOOR_W-1:0]       dest_floor = '0;
	logic                              cfg_we = 1'b0;
	logic [ess_pkg::LOAD_W-1:0]        cfg_data = '0;
	logic                              done;
	logic [ess_pkg::FLOOR_W-1:0]       car_floor;
	logic [ess_pkg::TIME_BITS-1:0]     elapsed;
	logic [ess_pkg::LOAD_W-1:0]        car_load;
	logic                              all_served;

	request_t requests[$];
	stop_t    stop_log[$];
	int       errors = 0;
	int       hold_off = 0;
	int       cycle_count = 0;
	bit       burst = 1'b0;

	// car model
	ess_pkg::slot_status_t             slot_st [ess_pkg::FLOORS];
	logic [ess_pkg::FLOOR_W-1:0]       slot_dst [ess_pkg::FLOORS];
	logic [ess_pkg::FLOOR_W-1:0]       car_at = '0;
	bit                                heading_down = 1'b0;
	logic [ess_pkg::TIME_BITS-1:0]     move_total = '1;
	logic [ess_pkg::LOAD_W-1:0]        riders = '0;
	logic [ess_pkg::LOAD_W-1:0]        capacity = ess_pkg::CAP_RESET;

	elevator_scan_scheduler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.origin_floor (origin_floor),
		.dest_floor   (dest_floor),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.done         (done),
		.car_floor    (car_floor),
		.elapsed      (elapsed),
		.car_load     (car_load),
		.all_served   (all_served)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < ess_pkg::FLOORS; k++) begin
			slot_st[k] = ess_pkg::ST_ABSENT;
			slot_dst[k] = '0;
		end
	end

	function automatic bit building_empty();
		bit empty;
		empty = 1'b1;
		for (int k = 0; k < ess_pkg::FLOORS; k++)
			if (slot_st[k] != ess_pkg::ST_ABSENT)
				empty = 1'b0;
		return empty;
	endfunction

	task automatic advance_car(input ess_pkg::op_t op, input logic [ess_pkg::FLOOR_W-1:0] org,
			input logic [ess_pkg::FLOOR_W-1:0] dst);
		bit    hit;
		bit    ahead;
		stop_t s;
		hit = 1'b0;
		ahead = 1'b0;
		if (op == ess_pkg::OP_REGISTER) begin
			if (org >= 1 && org <= ess_pkg::FLOORS && dst >= 1 && dst <= ess_pkg::FLOORS &&
					slot_st[int'(org) - 1] != ess_pkg::ST_RIDING) begin
				slot_st[int'(org) - 1] = ess_pkg::ST_WAITING;
				slot_dst[int'(org) - 1] = dst;
			end
		end else if (!building_empty()) begin
			move_total = move_total + 1'b1;
			if (heading_down)
				car_at = (car_at > 0) ? car_at - 1'b1 : '0;
			else
				car_at = car_at + 1'b1;
			for (int k = 0; k < ess_pkg::FLOORS; k++) begin
				if (slot_st[k] == ess_pkg::ST_RIDING && slot_dst[k] == car_at) begin
					hit = 1'b1;
					if (riders > 0)
						riders = riders - 1'b1;
					slot_st[k] = ess_pkg::ST_ABSENT;
					slot_dst[k] = '0;
				end
			end
			if (car_at >= 1 && car_at <= ess_pkg::FLOORS &&
					slot_st[int'(car_at) - 1] == ess_pkg::ST_WAITING &&
					riders < capacity) begin
				hit = 1'b1;
				slot_st[int'(car_at) - 1] = ess_pkg::ST_RIDING;
				riders = riders + 1'b1;
			end
			if (car_at >= ess_pkg::FLOORS) begin
				heading_down = 1'b1;
			end else if (car_at <= 1) begin
				heading_down = 1'b0;
			end else begin
				for (int k = 0; k < ess_pkg::FLOORS; k++) begin
					if (slot_st[k] != ess_pkg::ST_ABSENT) begin
						if (heading_down) begin
							if (k + 1 < car_at || slot_dst[k] < car_at)
								ahead = 1'b1;
						end else if (k + 1 > car_at || slot_dst[k] > car_at) begin
							ahead = 1'b1;
						end
					end
				end
				if (!ahead)
					heading_down = !heading_down;
			end
			if (hit) begin
				s.at_floor = car_at;
				s.moves = move_total;
				s.load = riders;
				s.served = building_empty();
				stop_log.push_back(s);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : drive
		request_t nxt;
		bit       taken;
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				advance_car(ess_pkg::op_t'(opcode), origin_floor, dest_floor);
				hold_off = pick_gap();
			end
			if (taken || !start) begin
				if (hold_off > 0) begin
					hold_off--;
					start <= 1'b0;
				end else if (requests.size() != 0) begin
					nxt = requests.pop_front();
					start <= 1'b1;
					opcode <= nxt.op;
					origin_floor <= nxt.org;
					dest_floor <= nxt.dst;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		stop_t want;
		if (arst_n && done) begin
			if (stop_log.size() == 0) begin
				$error("unexpected stop: car_floor %0d elapsed %0d car_load %0d all_served %0b",
					car_floor, elapsed, car_load, all_served);
				errors++;
			end else begin
				want = stop_log.pop_front();
				if (car_floor !== want.at_floor) begin
					$error("car_floor: expected %0d, got %0d", want.at_floor, car_floor);
					errors++;
				end
				if (elapsed !== want.moves) begin
					$error("elapsed: expected %0d, got %0d", want.moves, elapsed);
					errors++;
				end
				if (car_load !== want.load) begin
					$error("car_load: expected %0d, got %0d", want.load, car_load);
					errors++;
				end
				if (all_served !== want.served) begin
					$error("all_served: expected %0b, got %0b", want.served, all_served);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic request_t random_request(int tick_pct);
		request_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		r.op = ess_pkg::OP_REGISTER;
		r.org = ess_pkg::FLOOR_W'($urandom_range(1, ess_pkg::FLOORS));
		r.dst = ess_pkg::FLOOR_W'($urandom_range(1, ess_pkg::FLOORS));
		if (pick < tick_pct) begin
			r.op = ess_pkg::OP_TICK;
			r.org = ess_pkg::FLOOR_W'($urandom);
			r.dst = ess_pkg::FLOOR_W'($urandom);
		end else if (pick >= 94) begin
			// any 4-bit floor; 0 and 11 to 15 are out of range
			r.org = ess_pkg::FLOOR_W'($urandom);
			r.dst = ess_pkg::FLOOR_W'($urandom);
		end
		return r;
	endfunction

	task automatic queue_request(input ess_pkg::op_t op, input int org, input int dst);
		request_t r;
		r.op = op;
		r.org = ess_pkg::FLOOR_W'(org);
		r.dst = ess_pkg::FLOOR_W'(dst);
		requests.push_back(r);
	endtask

	// drain: all items taken, block idle, no stop pending, then let trailing work finish
	task automatic settle();
		while (requests.size() != 0 || start)
			@(posedge clk);
		repeat (2) @(posedge clk);
		while (busy || stop_log.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input logic [ess_pkg::LOAD_W-1:0] cap, input int count);
		int tick_pct;
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= cap;
		capacity = cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		burst = ($urandom_range(0, 3) == 0);
		tick_pct = $urandom_range(45, 75);
		repeat (count)
			requests.push_back(random_request(tick_pct));
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		queue_request(ess_pkg::OP_TICK, 0, 0);
		queue_request(ess_pkg::OP_REGISTER, 0, 5);
		queue_request(ess_pkg::OP_REGISTER, 11, 3);
		queue_request(ess_pkg::OP_REGISTER, 15, 15);
		queue_request(ess_pkg::OP_REGISTER, 4, 0);
		queue_request(ess_pkg::OP_REGISTER, 2, 13);
		queue_request(ess_pkg::OP_REGISTER, 1, 10);
		queue_request(ess_pkg::OP_REGISTER, 10, 1);
		queue_request(ess_pkg::OP_REGISTER, 3, 7);
		queue_request(ess_pkg::OP_REGISTER, 3, 8);
		queue_request(ess_pkg::OP_TICK, 5, 10);
		// floor 1 now has a rider: this one is dropped
		queue_request(ess_pkg::OP_REGISTER, 1, 4);
		repeat (10)
			queue_request(ess_pkg::OP_TICK, 15, 15);

		run_phase(4'd1, 80);
		run_phase(4'd15, 80);
		run_phase(4'd0, 45);
		run_phase(4'd9, 80);
		run_phase(4'd2, 80);
		run_phase(4'd15, 80);
		run_phase(ess_pkg::LOAD_W'($urandom_range(1, 15)), 80);

		settle();
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
